// ===== rtl/feel_pkg.sv =====
package feel_pkg;

	localparam int VALUE_W      = 15;
	localparam int READ_W       = 16;
	localparam int SLOT_FIELD_W = 10;

	localparam logic [READ_W-1:0] ERASED_SLOT = 16'hFFFF;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [VALUE_W-1:0] write_value;
	} cmd_t;

	typedef struct packed {
		logic [READ_W-1:0]       read_value;
		logic [SLOT_FIELD_W-1:0] slot_used;
		logic                    page_erased;
	} res_t;

endpackage

// ===== rtl/feel_slot_ram.sv =====
module feel_slot_ram
	import feel_pkg::*;
#(
	parameter int DEPTH  = 768,
	parameter int ADDR_W = 10
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/flash_eeprom_emulation_log.sv =====
// One-value EEPROM emulated in a page of SLOT_COUNT half-word slots.
// Command channel (cmd_valid / cmd_stall / cmd): operation 0 appends
// write_value (15 bits) to the next free slot, erasing the page first
// when it is full; operation 1 returns the most recently written value.
// Result channel (res_valid / res_stall / res): one beat per command,
// in command order.
// Slots always fill from slot 0 upward without gaps, so a fill count
// stands in for the erased marks: a write goes to slot fill, a read
// fetches slot fill-1, and a page erase just sets the count back.
// A write result passes through the pending stage and the output
// register to res; a read first passes the registered RAM read port.
// A new command is taken only once the last one has left the read
// stage and the single pending-result stage.
// Reset clears the fill count, which empties the page at once; no
// clearing pass runs and the first command is taken right after reset.
// While the receiver stalls, the result holds on res and one more
// command is still taken and finished into the pending stage; cmd_stall
// then rises until res drains.
module flash_eeprom_emulation_log_core
	import feel_pkg::*;
#(
	parameter int SLOT_COUNT = 768
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

	logic [CNT_W-1:0]   fill_q;
	logic               rd_valid_s1;
	logic               rd_empty_s1;
	logic [ADDR_W-1:0]  rd_slot_s1;
	logic               pend_valid_q;
	res_t               pend_q;
	logic               res_valid_q;
	res_t               res_q;

	logic               accept;
	logic               is_write;
	logic               is_read;
	logic               page_full;
	logic               page_empty;
	logic [ADDR_W-1:0]  wr_slot;
	logic [ADDR_W-1:0]  rd_slot;
	logic [VALUE_W-1:0] ram_rdata;
	logic               res_free;

	assign cmd_stall  = pend_valid_q | rd_valid_s1;
	assign accept     = cmd_valid & ~cmd_stall;
	assign is_write   = accept & (cmd.operation == OP_WRITE);
	assign is_read    = accept & (cmd.operation == OP_READ);
	assign page_full  = (fill_q == FULL_CNT);
	assign page_empty = (fill_q == '0);
	assign wr_slot    = page_full ? '0 : fill_q[ADDR_W-1:0];
	assign rd_slot    = ADDR_W'(fill_q - CNT_W'(1));
	assign res_free   = ~res_valid_q | ~res_stall;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [ADDR_W-1:0] idx);
		logic [SLOT_FIELD_W+ADDR_W-1:0] ext;
		ext = {{SLOT_FIELD_W{1'b0}}, idx};
		return ext[SLOT_FIELD_W-1:0];
	endfunction

	feel_slot_ram #(
		.DEPTH  (SLOT_COUNT),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (is_write),
		.waddr (wr_slot),
		.wdata (cmd.write_value),
		.re    (is_read & ~page_empty),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	// fill count and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= is_read;
			if (is_write) begin
				fill_q <= page_full ? CNT_W'(1) : fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) begin
			rd_empty_s1 <= page_empty;
			rd_slot_s1  <= rd_slot;
		end
	end

	// pending result: write finishes on acceptance, read in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (is_write || rd_valid_s1) begin
			pend_valid_q <= 1'b1;
		end else if (res_free) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_write) begin
			pend_q.read_value  <= '0;
			pend_q.slot_used   <= slot_field(wr_slot);
			pend_q.page_erased <= page_full;
		end else if (rd_valid_s1) begin
			pend_q.read_value  <= rd_empty_s1 ? ERASED_SLOT : {1'b0, ram_rdata};
			pend_q.slot_used   <= rd_empty_s1 ? '0 : slot_field(rd_slot_s1);
			pend_q.page_erased <= 1'b0;
		end
	end

	// output register: load from pending when free or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= pend_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && pend_valid_q) begin
			res_q <= pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
